FILE: hw/rtl/tans_range_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range table checker.
// The macros use the signals clock and reset of the enclosing module.
// ----------------------------------------------------------------------------
`ifndef TANS_RANGE_TABLE_TOP_ASSERT_SVH
`define TANS_RANGE_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("range table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TRT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("range table assertion failed");

// The condition must hold in the cycle after reset is seen.
`define TRT_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("range table reset assertion failed");

`endif

FILE: hw/rtl/trt_pkg.sv
// ----------------------------------------------------------------------------
// trt_pkg
// Types and constants shared by the range table controller, datapath and
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package trt_pkg;

   localparam int FUNC_W     = 3;
   localparam int SYM_BITS   = 8;
   localparam int FREQ_W     = 13;
   localparam int ST_W       = 12;
   localparam int VAL_W      = 13;
   localparam int OFF_W      = 13;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [FUNC_W-1:0] {
      FN_LOAD   = 3'd0,
      FN_INDEX  = 3'd1,
      FN_POS    = 3'd2,
      FN_BITS   = 3'd3,
      FN_SYMBOL = 3'd4,
      FN_START  = 3'd5
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_ABSENT   = 2'd1,
      ST_RANGE    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      VS_ZERO,
      VS_TOTAL,
      VS_INDEX,
      VS_POS,
      VS_BITS,
      VS_FREQ,
      VS_START
   } vsel_type;

   typedef struct packed {
      logic       capture;
      logic       new_table;
      logic       load_write;
      logic       fill_step;
      logic       walk_init;
      logic       div_init;
      logic       div_step;
      logic       walk_adv;
      logic       log_step;
      logic       finish;
      logic       total_add;
      logic       close;
      vsel_type   vsel;
      status_type status;
      logic       off_en;
      logic       sym_en;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     last;
      logic     sym_range;
      logic     sym_ok;
      logic     ovf;
      logic     freq_zero;
      logic     closed;
      logic     st_lt_start;
      logic     tgt_gt_f;
      logic     tgt_ge_f;
      logic     st_past;
      logic     walk_done;
      logic     hit;
      logic     div_last;
      logic     log_done;
      logic     fill_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/trt_ram.sv
// ----------------------------------------------------------------------------
// trt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/trt_dp.sv
// ----------------------------------------------------------------------------
// trt_dp
// Range table datapath: table memories, presence bits, range walk registers,
// a radix-2 divider, the bit-size shifter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_dp #(
   parameter int TABLE_SIZE = 4096,
   parameter int ALPHABET   = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire trt_pkg::cmd_type                   cmd,
   output trt_pkg::stat_type                       stat,
   input  wire logic [trt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [trt_pkg::FUNC_W-1:0]         req_tuser,
   input  wire logic                               req_tlast,
   output logic      [trt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import trt_pkg::*;

   localparam int LEN_W  = $clog2(TABLE_SIZE + 1);
   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int SYM_W  = $clog2(ALPHABET);
   localparam int SUM_W  = ((LEN_W > FREQ_W) ? LEN_W : FREQ_W) + 1;
   localparam int CNT_W  = $clog2(LEN_W + 1);
   localparam logic [SYM_BITS:0] SYM_LIM = (SYM_BITS + 1)'(ALPHABET);
   localparam logic [SUM_W-1:0]  SIZE_C  = SUM_W'(TABLE_SIZE);

   func_type              func_ff;
   logic [SYM_BITS-1:0]   sym_ff;
   logic [FREQ_W-1:0]     freq_ff;
   logic [ST_W-1:0]       st_ff;
   logic                  last_ff;

   logic [LEN_W-1:0]      total_ff;
   logic                  closed_ff;
   logic [ALPHABET-1:0]   present_ff;
   logic [ALPHABET-1:0]   start_vld_ff;

   logic [LEN_W-1:0]      len_ff;
   logic [FREQ_W-1:0]     f_ff;
   logic [LEN_W-1:0]      pos_ff;
   logic [FREQ_W-1:0]     idx_ff;
   logic [FREQ_W-1:0]     n_ff;
   logic [LEN_W-1:0]      q_ff;
   logic [FREQ_W-1:0]     rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      b_ff;
   logic [FREQ_W-1:0]     k_ff;

   logic [VAL_W-1:0]      value_ff;
   logic [OFF_W-1:0]      offset_ff;
   logic [SYM_BITS-1:0]   symout_ff;
   status_type            status_ff;

   logic [SYM_W-1:0]      sym_idx;
   logic [SYM_BITS-1:0]   sat_rd;
   logic [FREQ_W-1:0]     freq_rd;
   logic [ADDR_W-1:0]     start_rd;
   logic [ADDR_W-1:0]     start_eff;
   logic [SYM_W-1:0]      freq_raddr;
   logic                  sym_range;
   logic [SUM_W-1:0]      st_c;
   logic [SUM_W-1:0]      total_c;
   logic [SUM_W-1:0]      start_c;
   logic [SUM_W-1:0]      fr_c;
   logic [SUM_W-1:0]      diff_c;
   logic [FREQ_W:0]       shifted;
   logic                  ge;
   logic [VAL_W-1:0]      value_in;
   logic [OFF_W-1:0]      offset_in;
   logic [SYM_BITS-1:0]   symout_in;

   assign sym_idx    = SYM_W'(sym_ff);
   assign freq_raddr = (func_ff == FN_SYMBOL) ? SYM_W'(sat_rd) : sym_idx;
   assign sym_range  = {1'b0, sym_ff} < SYM_LIM;
   assign start_eff  = (sym_range && start_vld_ff[sym_idx]) ? start_rd : '0;

   assign st_c    = SUM_W'(st_ff);
   assign total_c = SUM_W'(total_ff);
   assign start_c = SUM_W'(start_eff);
   assign fr_c    = SUM_W'(freq_rd);
   assign diff_c  = st_c - start_c;

   assign shifted = {rem_ff, q_ff[LEN_W-1]};
   assign ge      = shifted >= {1'b0, f_ff};

   trt_ram #(.WIDTH(SYM_BITS), .DEPTH(TABLE_SIZE)) u_sat_ram (
      .clock   (clock),
      .wr_en   (cmd.fill_step),
      .wr_addr (ADDR_W'(total_c + SUM_W'(k_ff))),
      .wr_data (sym_ff),
      .rd_addr (ADDR_W'(st_ff)),
      .rd_data (sat_rd)
   );

   trt_ram #(.WIDTH(FREQ_W), .DEPTH(ALPHABET)) u_freq_ram (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (sym_idx),
      .wr_data (freq_ff),
      .rd_addr (freq_raddr),
      .rd_data (freq_rd)
   );

   trt_ram #(.WIDTH(ADDR_W), .DEPTH(ALPHABET)) u_start_ram (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (sym_idx),
      .wr_data (ADDR_W'(total_ff)),
      .rd_addr (sym_idx),
      .rd_data (start_rd)
   );

   always_comb begin
      stat.func        = func_ff;
      stat.last        = last_ff;
      stat.sym_range   = sym_range;
      stat.sym_ok      = sym_range && present_ff[sym_idx];
      stat.ovf         = (total_c + SUM_W'(freq_ff)) > SIZE_C;
      stat.freq_zero   = (freq_ff == '0);
      stat.closed      = closed_ff;
      stat.st_lt_start = st_c < start_c;
      stat.tgt_gt_f    = diff_c > fr_c;
      stat.tgt_ge_f    = diff_c >= fr_c;
      stat.st_past     = (st_c >= total_c) || (st_c >= SIZE_C);
      stat.walk_done   = (func_ff == FN_INDEX) ? (f_ff == '0) : (n_ff == '0);
      stat.hit         = (SUM_W'(pos_ff) + SUM_W'(q_ff)) > st_c;
      stat.div_last    = cnt_ff == CNT_W'(LEN_W - 1);
      stat.log_done    = q_ff <= LEN_W'(1);
      stat.fill_last   = k_ff == (freq_ff - FREQ_W'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_tuser);
         sym_ff  <= req_tdata[7:0];
         freq_ff <= req_tdata[20:8];
         st_ff   <= req_tdata[32:21];
         last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         closed_ff    <= 1'b1;
         present_ff   <= '0;
         start_vld_ff <= '0;
      end else begin
         if (cmd.new_table) begin
            total_ff   <= '0;
            closed_ff  <= 1'b0;
            present_ff <= '0;
         end
         if (cmd.load_write) begin
            present_ff[sym_idx]   <= 1'b1;
            start_vld_ff[sym_idx] <= 1'b1;
         end
         if (cmd.finish && cmd.total_add) begin
            total_ff <= total_ff + LEN_W'(freq_ff);
         end
         if (cmd.finish && cmd.close) begin
            closed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         k_ff <= '0;
      end else if (cmd.fill_step) begin
         k_ff <= k_ff + FREQ_W'(1);
      end
      if (cmd.walk_init) begin
         len_ff <= total_ff;
         f_ff   <= freq_rd;
         pos_ff <= '0;
         idx_ff <= '0;
         n_ff   <= FREQ_W'(diff_c);
      end else if (cmd.walk_adv) begin
         len_ff <= len_ff - q_ff;
         f_ff   <= f_ff - FREQ_W'(1);
         pos_ff <= pos_ff + q_ff;
         idx_ff <= idx_ff + FREQ_W'(1);
         n_ff   <= n_ff - FREQ_W'(1);
      end
      if (cmd.div_init) begin
         q_ff   <= len_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
         b_ff   <= '0;
      end else if (cmd.div_step) begin
         q_ff   <= {q_ff[LEN_W-2:0], ge};
         rem_ff <= ge ? FREQ_W'(shifted - {1'b0, f_ff}) : FREQ_W'(shifted);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else if (cmd.log_step) begin
         q_ff <= q_ff >> 1;
         b_ff <= b_ff + CNT_W'(1);
      end
   end

   always_comb begin
      unique case (cmd.vsel)
         VS_ZERO:  value_in = '0;
         VS_TOTAL: value_in = VAL_W'(total_ff);
         VS_INDEX: value_in = idx_ff;
         VS_POS:   value_in = VAL_W'(pos_ff);
         VS_BITS:  value_in = VAL_W'(b_ff);
         VS_FREQ:  value_in = freq_rd;
         VS_START: value_in = VAL_W'(start_eff);
         default:  value_in = '0;
      endcase
      offset_in = cmd.off_en ? (OFF_W'(st_ff) - OFF_W'(pos_ff)) : '0;
      symout_in = cmd.sym_en ? sat_rd : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         value_ff  <= value_in;
         offset_ff <= offset_in;
         symout_ff <= symout_in;
         status_ff <= cmd.status;
      end
   end

   assign rsp_tdata = {4'b0000, status_ff, symout_ff, offset_ff, value_ff};

endmodule

`default_nettype wire

FILE: hw/rtl/trt_ctrl.sv
// ----------------------------------------------------------------------------
// trt_ctrl
// Range table controller: sequences loads, range walks, divisions and the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire trt_pkg::stat_type stat,
   output trt_pkg::cmd_type       cmd
);

   import trt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_DISPATCH,
      S_FILL,
      S_WALK,
      S_DIV,
      S_STEP,
      S_FDIV,
      S_LOG,
      S_SYMW,
      S_OUT
   } state_type;

   state_type  state_ff, state_in;
   vsel_type   vsel_ff, vsel_in;
   status_type stat_ff, stat_in;
   logic       off_en_ff, off_en_in;
   logic       sym_en_ff, sym_en_in;
   logic       total_add_ff, total_add_in;
   logic       close_ff, close_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in      = state_ff;
      vsel_in       = vsel_ff;
      stat_in       = stat_ff;
      off_en_in     = off_en_ff;
      sym_en_in     = sym_en_ff;
      total_add_in  = total_add_ff;
      close_in      = close_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.vsel      = vsel_ff;
      cmd.status    = stat_ff;
      cmd.off_en    = off_en_ff;
      cmd.sym_en    = sym_en_ff;
      cmd.total_add = total_add_ff;
      cmd.close     = close_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            off_en_in    = 1'b0;
            sym_en_in    = 1'b0;
            total_add_in = 1'b0;
            close_in     = 1'b0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.new_table = (stat.func == FN_LOAD) && stat.closed;
            state_in      = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_OUT;
            vsel_in  = VS_ZERO;
            stat_in  = ST_OK;
            unique case (stat.func)
               FN_LOAD: begin
                  close_in = stat.last;
                  priority if (!stat.sym_range) begin
                     stat_in = ST_ABSENT;
                  end else if (stat.ovf) begin
                     vsel_in = VS_TOTAL;
                     stat_in = ST_OVERFLOW;
                  end else if (stat.freq_zero) begin
                     vsel_in = VS_TOTAL;
                  end else begin
                     vsel_in        = VS_TOTAL;
                     total_add_in   = 1'b1;
                     cmd.load_write = 1'b1;
                     state_in       = S_FILL;
                  end
               end
               FN_INDEX: begin
                  if (!stat.sym_ok) begin
                     stat_in = ST_ABSENT;
                  end else begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_WALK;
                  end
               end
               FN_POS: begin
                  priority if (!stat.sym_ok) begin
                     stat_in = ST_ABSENT;
                  end else if (stat.st_lt_start || stat.tgt_gt_f) begin
                     stat_in = ST_RANGE;
                  end else begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_WALK;
                  end
               end
               FN_BITS: begin
                  priority if (!stat.sym_ok) begin
                     stat_in = ST_ABSENT;
                  end else if (stat.st_lt_start || stat.tgt_ge_f) begin
                     stat_in = ST_RANGE;
                  end else begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_WALK;
                  end
               end
               FN_SYMBOL: begin
                  if (stat.st_past) begin
                     stat_in = ST_RANGE;
                  end else begin
                     vsel_in   = VS_FREQ;
                     sym_en_in = 1'b1;
                     state_in  = S_SYMW;
                  end
               end
               FN_START: begin
                  vsel_in = VS_START;
                  stat_in = stat.sym_ok ? ST_OK : ST_ABSENT;
               end
               default: begin
                  vsel_in = VS_ZERO;
               end
            endcase
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               state_in = S_OUT;
            end
         end
         S_WALK: begin
            if (stat.walk_done) begin
               priority if (stat.func == FN_BITS) begin
                  cmd.div_init = 1'b1;
                  state_in     = S_FDIV;
               end else if (stat.func == FN_INDEX) begin
                  vsel_in   = VS_INDEX;
                  stat_in   = ST_RANGE;
                  off_en_in = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  vsel_in  = VS_POS;
                  stat_in  = ST_OK;
                  state_in = S_OUT;
               end
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if ((stat.func == FN_INDEX) && stat.hit) begin
               vsel_in   = VS_INDEX;
               stat_in   = ST_OK;
               off_en_in = 1'b1;
               state_in  = S_OUT;
            end else begin
               cmd.walk_adv = 1'b1;
               state_in     = S_WALK;
            end
         end
         S_FDIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            if (stat.log_done) begin
               vsel_in  = VS_BITS;
               stat_in  = ST_OK;
               state_in = S_OUT;
            end else begin
               cmd.log_step = 1'b1;
            end
         end
         S_SYMW: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.finish    = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vsel_ff       <= VS_ZERO;
         stat_ff       <= ST_OK;
         off_en_ff     <= 1'b0;
         sym_en_ff     <= 1'b0;
         total_add_ff  <= 1'b0;
         close_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vsel_ff       <= vsel_in;
         stat_ff       <= stat_in;
         off_en_ff     <= off_en_in;
         sym_en_ff     <= sym_en_in;
         total_add_ff  <= total_add_in;
         close_ff      <= close_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tans_range_table_top.sv
// Sequence: a load is captured, looked up and dispatched, then fills its states;
// a query walks its ranges, each with a full pass of the bit-serial divider,
// and a bit size query adds one more division and one shift per result bit.
// Throughput: one transaction at a time; the walk loop and its bit-serial
// divider set the rate, the fill of the state memory one entry per cycle.
// Reset: synchronous; presence and start valid bits clear at once, with no
// clearing pass, and the table starts closed and empty.
// ----------------------------------------------------------------------------
// tans_range_table_top
// Builds and queries a symbol/state range table over stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tans_range_table_top #(
   parameter int TABLE_SIZE = 4096,
   parameter int ALPHABET   = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // symbol_code [7:0], frequency [20:8], state_value [32:21], zero fill
   input  wire logic [trt_pkg::REQ_DATA_W-1:0] req_tdata,
   // func [2:0]
   input  wire logic [trt_pkg::FUNC_W-1:0]     req_tuser,
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // value [12:0], offset [25:13], symbol_out [33:26], status [35:34], zero fill
   output logic      [trt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import trt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   trt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   trt_dp #(.TABLE_SIZE(TABLE_SIZE), .ALPHABET(ALPHABET)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/trt_checker.sv
// ----------------------------------------------------------------------------
// trt_checker
// Port-level checks of the range table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tans_range_table_top_assert.svh"

module trt_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [trt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import trt_pkg::*;

   `TRT_ASSERT_RESET(a_no_rsp_after_reset, !rsp_tvalid)
   `TRT_ASSERT_NEXT(a_rsp_held, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `TRT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `TRT_ASSERT_SAME(a_symbol_ok, rsp_tvalid && (rsp_tdata[33:26] != '0), rsp_tdata[35:34] == ST_OK)
   `TRT_ASSERT_SAME(a_offset_status, rsp_tvalid && (rsp_tdata[25:13] != '0), (rsp_tdata[35:34] == ST_OK) || (rsp_tdata[35:34] == ST_RANGE))

endmodule

bind tans_range_table_top trt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: tb/tans_range_table_top_test.sv
// ----------------------------------------------------------------------------
// tans_range_table_top_test
// Loads symbol/state tables and queries them through the stream channels.
// An in-bench table model predicts every response, which is then compared
// field by field in order of arrival, under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tans_range_table_top_test;
   import trt_pkg::*;

   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
   localparam int TBL_SIZE   = 4096;
   localparam int CYCLE_CAP  = 20000000;

   typedef struct {
      logic [VAL_W-1:0]  value;
      logic [OFF_W-1:0]  offset;
      logic [7:0]        symbol;
      logic [STAT_W-1:0] status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   tans_range_table_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // Table model.
   logic [7:0] sym_at_state [TBL_SIZE];
   int freq_of [256];
   int start_of [256];
   bit present [256];
   int total_len;
   bit closed;

   answer_type pending_answers [$];
   int send_idle_pct, recv_stall_pct;
   int fail_count;
   int item_count;
   int cycle_count;

   function automatic answer_type predict(logic [2:0] func, int sym, int freq, int st,
                                          bit last);
      answer_type a;
      int f, len, pos, idx, rl, target, b, i;
      bit found;
      a.value = '0; a.offset = '0; a.symbol = '0; a.status = ST_OK;
      case (func)
         FN_LOAD: begin
            if (closed) begin
               foreach (present[k]) present[k] = 0;
               total_len = 0;
               closed = 0;
            end
            a.value = VAL_W'(total_len);
            if (total_len + freq > TBL_SIZE) begin
               a.status = ST_OVERFLOW;
            end else if (freq != 0) begin
               start_of[sym] = total_len;
               freq_of[sym] = freq;
               present[sym] = 1;
               for (i = 0; i < freq; i++) sym_at_state[total_len + i] = 8'(sym);
               total_len += freq;
            end
            if (last) closed = 1;
         end
         FN_INDEX: begin
            if (!present[sym]) begin
               a.status = ST_ABSENT;
            end else begin
               f = freq_of[sym]; len = total_len; pos = 0; idx = 0; found = 0;
               while (f > 0) begin
                  rl = len / f;
                  if (pos + rl > st) begin
                     found = 1;
                     break;
                  end
                  pos += rl; len -= rl; f--; idx++;
               end
               a.value = VAL_W'(idx);
               a.offset = OFF_W'(st - pos);
               if (!found) a.status = ST_RANGE;
            end
         end
         FN_POS, FN_BITS: begin
            if (!present[sym]) begin
               a.status = ST_ABSENT;
            end else begin
               target = st - start_of[sym];
               f = freq_of[sym];
               if (target < 0 || target > f || (func == FN_BITS && target == f)) begin
                  a.status = ST_RANGE;
               end else begin
                  len = total_len; pos = 0;
                  for (i = 0; i < target && f > 0; i++) begin
                     rl = len / f; len -= rl; f--; pos += rl;
                  end
                  if (func == FN_POS) begin
                     a.value = VAL_W'(pos);
                  end else begin
                     rl = (f > 0) ? len / f : 0;
                     b = 0;
                     while (rl > 1) begin
                        rl >>= 1; b++;
                     end
                     a.value = VAL_W'(b);
                  end
               end
            end
         end
         FN_SYMBOL: begin
            if (st >= total_len) begin
               a.status = ST_RANGE;
            end else begin
               a.symbol = sym_at_state[st];
               a.value = VAL_W'(freq_of[sym_at_state[st]]);
            end
         end
         FN_START: begin
            a.value = VAL_W'(start_of[sym]);
            if (!present[sym]) a.status = ST_ABSENT;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic send_item(logic [2:0] func, int sym, int freq, int st, bit last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tlast <= last;
      req_tdata <= {7'b0, st[11:0], freq[12:0], sym[7:0]};
      pending_answers.push_back(predict(func, sym, freq, st, last));
      item_count++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response transaction");
            fail_count++;
         end else begin
            a = pending_answers.pop_front();
            if (rsp_tdata[12:0] !== a.value) begin
               $error("value: expected %0d, actual %0d", a.value, rsp_tdata[12:0]);
               fail_count++;
            end
            if (rsp_tdata[25:13] !== a.offset) begin
               $error("offset: expected %0d, actual %0d", a.offset, rsp_tdata[25:13]);
               fail_count++;
            end
            if (rsp_tdata[33:26] !== a.symbol) begin
               $error("symbol_out: expected %0d, actual %0d", a.symbol, rsp_tdata[33:26]);
               fail_count++;
            end
            if (rsp_tdata[35:34] !== a.status) begin
               $error("status: expected %0d, actual %0d", a.status, rsp_tdata[35:34]);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_full_table;
      send_item(FN_LOAD, 8'hA5, 4096, 0, 1);
      send_item(FN_SYMBOL, 0, 0, 4095, 0);
      send_item(FN_INDEX, 8'hA5, 0, 4095, 0);
      send_item(FN_POS, 8'hA5, 0, 4095, 0);
      send_item(FN_BITS, 8'hA5, 0, 0, 0);
      send_item(FN_START, 8'hA5, 0, 0, 0);
   endtask

   task automatic test_load_cases;
      send_item(FN_LOAD, 0, 1, 0, 0);
      send_item(FN_INDEX, 0, 0, 0, 0);
      send_item(FN_LOAD, 255, 4096, 0, 0);
      send_item(FN_LOAD, 7, 8191, 0, 0);
      send_item(FN_LOAD, 9, 0, 0, 0);
      send_item(FN_LOAD, 255, 20, 0, 0);
      send_item(FN_LOAD, 0, 5, 0, 1);
      send_item(FN_START, 9, 0, 0, 0);
      send_item(FN_SYMBOL, 0, 0, 26, 0);
      send_item(FN_SYMBOL, 0, 0, 2, 0);
      send_item(FN_POS, 255, 0, 0, 0);
      send_item(FN_POS, 255, 0, 21, 0);
      send_item(FN_BITS, 255, 0, 21, 0);
      send_item(FN_BITS, 0, 0, 24, 0);
      send_item(FN_INDEX, 3, 0, 0, 0);
      send_item(FN_SPARE_LO, 1, 1, 1, 0);
      send_item(FN_SPARE_HI, 255, 8191, 4095, 1);
   endtask

   task automatic test_random_tables(int target_items);
      int syms [$];
      int n, q, s, f, st;
      logic [2:0] fn;
      while (item_count < target_items) begin
         syms.delete();
         n = $urandom_range(2, 10);
         for (int i = 0; i < n; i++) begin
            s = $urandom_range(255);
            q = $urandom_range(99);
            if (q < 5) f = 0;
            else if (q < 8) f = $urandom_range(8191);
            else if (q < 14) f = $urandom_range(100, 600);
            else f = $urandom_range(1, 40);
            syms.push_back(s);
            send_item(FN_LOAD, s, f, $urandom_range(4095),
                      (i == n - 1) || ($urandom_range(99) < 3));
            if ($urandom_range(99) < 15)
               send_item(FN_START, syms[$urandom_range(syms.size() - 1)], 0, 0, 0);
         end
         q = $urandom_range(5, 20);
         for (int i = 0; i < q; i++) begin
            s = ($urandom_range(99) < 85) ? syms[$urandom_range(syms.size() - 1)]
                                          : $urandom_range(255);
            case ($urandom_range(6))
               0: fn = FN_INDEX;
               1: fn = FN_POS;
               2: fn = FN_BITS;
               3: fn = FN_SYMBOL;
               4: fn = FN_START;
               5: fn = ($urandom_range(1)) ? FN_POS : FN_BITS;
               default: fn = ($urandom_range(9) == 0) ? FN_SPARE_LO : FN_INDEX;
            endcase
            if ($urandom_range(9) == 0) st = $urandom_range(4095);
            else if (fn == FN_POS || fn == FN_BITS)
               st = start_of[s] + $urandom_range(freq_of[s] + 1);
            else st = $urandom_range(total_len + 2);
            if (st > 4095) st = 4095;
            send_item(fn, s, $urandom_range(8191), st, $urandom_range(1));
         end
      end
   endtask

   initial begin
      fail_count = 0; item_count = 0; cycle_count = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      closed = 1; total_len = 0;
      foreach (present[k]) begin
         present[k] = 0; start_of[k] = 0; freq_of[k] = 0;
      end
      foreach (sym_at_state[k]) sym_at_state[k] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_full_table();
      test_load_cases();
      drain();
      test_random_tables(180);
      drain();
      send_idle_pct = 46;
      test_random_tables(340);
      drain();
      send_idle_pct = 0; recv_stall_pct = 46;
      test_random_tables(500);
      drain();
      send_idle_pct = 18; recv_stall_pct = 18;
      test_random_tables(670);
      drain();
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
